FILE: rtl/rse_pkg.sv
// Shared types and constants of the RPN stack evaluator.
package rse_pkg;

   localparam int DATA_W = 32;
   localparam int CMD_W = 3;
   localparam int STATUS_W = 2;
   localparam int COUNT_OUT_W = 5;
   localparam int STACK_DEPTH_DEF = 16;

   localparam logic [CMD_W-1:0] CMD_PUSH   = 3'd0;
   localparam logic [CMD_W-1:0] CMD_ADD    = 3'd1;
   localparam logic [CMD_W-1:0] CMD_SUB    = 3'd2;
   localparam logic [CMD_W-1:0] CMD_MUL    = 3'd3;
   localparam logic [CMD_W-1:0] CMD_DIV    = 3'd4;
   localparam logic [CMD_W-1:0] CMD_FINISH = 3'd5;

   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
   localparam logic [STATUS_W-1:0] ST_DIVZERO   = 2'd3;

   // cell moves: hold, take the neighbor above (push), take the neighbor below (pop)
   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_DOWN,
      CELL_UP
   } cell_op_type;

   typedef struct packed {
      logic [CMD_W-1:0]         command;
      logic signed [DATA_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] top_value;
      logic                     top_valid;
      logic [COUNT_OUT_W-1:0]   stack_count;
      logic [STATUS_W-1:0]      status;
   } rsp_type;

endpackage

FILE: rtl/rse_cell.sv
// One stack cell: holds one entry and shifts with its neighbors.
module rse_cell
   import rse_pkg::*;
(
   input  logic              clock,
   input  cell_op_type       op,
   input  logic [DATA_W-1:0] from_above,
   input  logic [DATA_W-1:0] from_below,
   output logic [DATA_W-1:0] value_out
);

   logic [DATA_W-1:0] value_ff;
   logic [DATA_W-1:0] value_in;

   always_comb begin
      case (op)
         CELL_DOWN: value_in = from_above;
         CELL_UP:   value_in = from_below;
         default:   value_in = value_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value_out = value_ff;

endmodule

FILE: rtl/rse_divider.sv
// Signed 32-bit divider, truncating, one quotient bit per cycle.
module rse_divider
   import rse_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DATA_W-1:0] dividend,
   input  logic [DATA_W-1:0] divisor,
   output logic              done,
   output logic [DATA_W-1:0] quotient
);

   localparam int CNT_W = $clog2(DATA_W);

   logic              run_ff, run_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [DATA_W-1:0] rem_ff, rem_in;
   logic [DATA_W-1:0] quo_ff, quo_in;
   logic [DATA_W-1:0] dvs_ff, dvs_in;
   logic              neg_ff, neg_in;
   logic [DATA_W:0]   trial;

   assign trial = {rem_ff, quo_ff[DATA_W-1]} - {1'b0, dvs_ff};

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      neg_in  = neg_ff;
      if (start) begin
         run_in = 1'b1;
         cnt_in = '0;
         rem_in = '0;
         quo_in = dividend[DATA_W-1] ? (DATA_W'(0) - dividend) : dividend;
         dvs_in = divisor[DATA_W-1] ? (DATA_W'(0) - divisor) : divisor;
         neg_in = dividend[DATA_W-1] ^ divisor[DATA_W-1];
      end else if (run_ff) begin
         if (!trial[DATA_W]) begin
            rem_in = trial[DATA_W-1:0];
            quo_in = {quo_ff[DATA_W-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[DATA_W-2:0], quo_ff[DATA_W-1]};
            quo_in = {quo_ff[DATA_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(DATA_W - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      neg_ff <= neg_in;
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? (DATA_W'(0) - quo_ff) : quo_ff;

endmodule

FILE: rtl/rpn_stack_evaluator.sv
// Top level of the RPN stack evaluator: cell chain stack, ALU and control.
//
// Evaluates Reverse Polish expressions, one token per beat. A token is taken
// at a rising edge with start high and busy low; exactly one result beat
// follows, shown for one cycle with rsp_valid high. The receiver cannot stall,
// so every result must be captured in the cycle it is shown. The stack is a
// row of STACK_DEPTH cells with the top in cell 0; push shifts the row down,
// pop shifts it up, so the two operands always sit in cells 0 and 1.
// Timing: push, add, subtract, multiply, finish and unused codes answer in the
// cycle after acceptance and busy stays low, so these run at one token per
// cycle. Division by zero holds busy in POP_SECOND (a second pop through the
// chain). A real division holds busy in DIVIDE while the divider loads and
// produces one quotient bit per cycle over 32 bits, then the top writes back.
// stack_count reports the entry count masked to 5 bits. Stack entries have no
// reset; only the entry count is cleared.
module rpn_stack_evaluator
   import rse_pkg::*;
#(
   parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_item,
   output logic    rsp_valid,
   output rsp_type rsp_item
);

   localparam int CW = $clog2(STACK_DEPTH + 1);
   localparam int PW = (CW > COUNT_OUT_W) ? CW : COUNT_OUT_W;

   typedef enum logic [1:0] {
      IDLE,
      DIVIDE,
      POP_SECOND
   } state_type;

   state_type         state_ff, state_in;
   logic [CW-1:0]     count_ff, count_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_item_ff, rsp_item_in;

   // cell chain
   logic [DATA_W-1:0] cell_q [STACK_DEPTH];
   cell_op_type       top_op, rest_op;
   logic [DATA_W-1:0] top_load;

   // operands: b is the top, a the entry below
   logic [DATA_W-1:0]   b_val, a_val;
   logic [DATA_W-1:0]   alu_sum, alu_diff;
   logic [2*DATA_W-1:0] prod_full;
   logic                accept;
   logic                div_start, div_done;
   logic [DATA_W-1:0]   div_quo;
   logic [PW-1:0]       count_pad;

   assign b_val     = cell_q[0];
   assign a_val     = cell_q[1];
   assign alu_sum   = a_val + b_val;
   assign alu_diff  = a_val - b_val;
   assign prod_full = a_val * b_val;   // low half is the wrapped product
   assign accept    = start && (state_ff == IDLE);

   for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
      logic [DATA_W-1:0] above, below;
      cell_op_type       op;
      if (i == 0) begin : g_top
         assign above = top_load;
         assign op    = top_op;
      end else begin : g_mid
         assign above = cell_q[i-1];
         assign op    = rest_op;
      end
      if (i == STACK_DEPTH - 1) begin : g_last
         assign below = cell_q[i];
      end else begin : g_inner
         assign below = cell_q[i+1];
      end
      rse_cell u_cell (
         .clock      (clock),
         .op         (op),
         .from_above (above),
         .from_below (below),
         .value_out  (cell_q[i])
      );
   end

   rse_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (a_val),
      .divisor  (b_val),
      .done     (div_done),
      .quotient (div_quo)
   );

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      rsp_valid_in = 1'b0;
      rsp_item_in  = rsp_item_ff;
      rsp_item_in.stack_count = '0;   // taken from the count register on output
      top_op    = CELL_HOLD;
      rest_op   = CELL_HOLD;
      top_load  = req_item.value;
      div_start = 1'b0;

      case (state_ff)
         IDLE: begin
            if (accept) begin
               rsp_valid_in          = 1'b1;
               rsp_item_in.status    = ST_OK;
               rsp_item_in.top_valid = (count_ff != '0);
               rsp_item_in.top_value = (count_ff != '0) ? b_val : '0;
               case (req_item.command)
                  CMD_PUSH: begin
                     if (count_ff == CW'(STACK_DEPTH)) begin
                        rsp_item_in.status = ST_FULL;
                     end else begin
                        top_op   = CELL_DOWN;
                        rest_op  = CELL_DOWN;
                        count_in = count_ff + CW'(1);
                        rsp_item_in.top_valid = 1'b1;
                        rsp_item_in.top_value = req_item.value;
                     end
                  end
                  CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV: begin
                     if (count_ff < CW'(2)) begin
                        // one operand short: a lone entry is popped and lost
                        if (count_ff == CW'(1)) begin
                           top_op  = CELL_UP;
                           rest_op = CELL_UP;
                        end
                        count_in = '0;
                        rsp_item_in.status    = ST_UNDERFLOW;
                        rsp_item_in.top_valid = 1'b0;
                        rsp_item_in.top_value = '0;
                     end else if (req_item.command == CMD_DIV) begin
                        rsp_valid_in = 1'b0;
                        if (b_val == '0) begin
                           top_op   = CELL_UP;
                           rest_op  = CELL_UP;
                           count_in = count_ff - CW'(1);
                           state_in = POP_SECOND;
                        end else begin
                           div_start = 1'b1;
                           state_in  = DIVIDE;
                        end
                     end else begin
                        case (req_item.command)
                           CMD_ADD: top_load = alu_sum;
                           CMD_SUB: top_load = alu_diff;
                           default: top_load = prod_full[DATA_W-1:0];
                        endcase
                        top_op   = CELL_DOWN;
                        rest_op  = CELL_UP;
                        count_in = count_ff - CW'(1);
                        rsp_item_in.top_valid = 1'b1;
                        rsp_item_in.top_value = top_load;
                     end
                  end
                  CMD_FINISH: begin
                     count_in = '0;
                  end
                  default: begin
                     // unused codes: report the top, change nothing
                  end
               endcase
            end
         end
         POP_SECOND: begin
            // divide by zero: drop the first operand too
            top_op       = CELL_UP;
            rest_op      = CELL_UP;
            count_in     = count_ff - CW'(1);
            state_in     = IDLE;
            rsp_valid_in = 1'b1;
            rsp_item_in.status    = ST_DIVZERO;
            rsp_item_in.top_valid = (count_in != '0);
            rsp_item_in.top_value = (count_in != '0) ? a_val : '0;
         end
         DIVIDE: begin
            if (div_done) begin
               top_load     = div_quo;
               top_op       = CELL_DOWN;
               rest_op      = CELL_UP;
               count_in     = count_ff - CW'(1);
               state_in     = IDLE;
               rsp_valid_in = 1'b1;
               rsp_item_in.status    = ST_OK;
               rsp_item_in.top_valid = 1'b1;
               rsp_item_in.top_value = div_quo;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_item_ff <= rsp_item_in;
   end

   // count register already holds the post-step count while the result shows
   assign count_pad = PW'(count_ff);

   always_comb begin
      rsp_item = rsp_item_ff;
      rsp_item.stack_count = count_pad[COUNT_OUT_W-1:0];
   end

   assign rsp_valid = rsp_valid_ff;
   assign busy      = (state_ff != IDLE);

endmodule

FILE: rtl/rse_checker.sv
// Port-level checks of the RPN stack evaluator, bound to the top level.
module rse_checker
   import rse_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input logic    rsp_valid,
   input rsp_type rsp_item
);

   // an accepted beat is answered next cycle or keeps the block busy
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (rsp_valid || busy))
      else $error("accepted token neither answered nor in progress");

   // leaving a multi-cycle operation always delivers its result
   a_busy_end_result: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_valid)
      else $error("busy dropped without a result beat");

   // no result while an operation is still in flight
   a_no_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      (busy && $past(busy)) |-> !rsp_valid)
      else $error("result beat during a running operation");

   // an empty top reads as zero; a dropped push leaves a non-empty stack
   a_top_consistent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_item.top_valid || rsp_item.top_value == '0) &&
                     (rsp_item.status != ST_FULL || rsp_item.top_valid)))
      else $error("inconsistent top of stack in result beat");

endmodule

bind rpn_stack_evaluator rse_checker u_rse_checker (.*);

FILE: verif/rpn_result_checker.sv
// Result checker for the RPN stack evaluator: own stack model, owed-result queue, compare.
module rpn_result_checker
   import rse_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  logic    busy,
   input  req_type req_item,
   input  logic    rsp_valid,
   input  rsp_type rsp_item,
   output int      mismatch_count,
   output int      answers_owed
);

   logic [DATA_W-1:0] stack_cells [STACK_DEPTH_DEF];
   int unsigned       stack_fill;
   rsp_type           owed_answers [$];
   rsp_type           oldest;

   initial begin
      mismatch_count = 0;
      answers_owed   = 0;
      stack_fill     = 0;
   end

   task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                  input logic [DATA_W-1:0] want);
      $display("%0t: %s got %0h expected %0h", $time, what, got, want);
      mismatch_count++;
   endtask

   // signed divide, truncating toward zero; most negative / -1 wraps
   function automatic logic [DATA_W-1:0] quotient_toward_zero(input logic [DATA_W-1:0] num,
                                                              input logic [DATA_W-1:0] den);
      logic [DATA_W-1:0] num_mag;
      logic [DATA_W-1:0] den_mag;
      logic [DATA_W-1:0] mag;
      num_mag = num[DATA_W-1] ? -num : num;
      den_mag = den[DATA_W-1] ? -den : den;
      mag     = num_mag / den_mag;
      return (num[DATA_W-1] ^ den[DATA_W-1]) ? -mag : mag;
   endfunction

   // applies one token to the stack model and returns the result beat it owes
   function automatic rsp_type evaluate_token(input req_type tok);
      rsp_type           ans;
      logic [DATA_W-1:0] lhs;
      logic [DATA_W-1:0] rhs;
      logic [DATA_W-1:0] res;
      logic              keep;
      ans        = '0;
      ans.status = ST_OK;
      res        = '0;
      keep       = 1'b1;
      case (tok.command)
         CMD_PUSH: begin
            if (stack_fill >= STACK_DEPTH_DEF) begin
               ans.status = ST_FULL;
            end else begin
               stack_cells[stack_fill] = tok.value;
               stack_fill++;
            end
         end
         CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV: begin
            if (stack_fill == 0) begin
               ans.status = ST_UNDERFLOW;
            end else if (stack_fill == 1) begin
               stack_fill = 0;
               ans.status = ST_UNDERFLOW;
            end else begin
               rhs = stack_cells[stack_fill-1];
               lhs = stack_cells[stack_fill-2];
               stack_fill -= 2;
               case (tok.command)
                  CMD_ADD: res = lhs + rhs;
                  CMD_SUB: res = lhs - rhs;
                  CMD_MUL: res = lhs * rhs;
                  default: begin
                     if (rhs == '0) begin
                        ans.status = ST_DIVZERO;
                        keep       = 1'b0;
                     end else begin
                        res = quotient_toward_zero(lhs, rhs);
                     end
                  end
               endcase
               if (keep) begin
                  stack_cells[stack_fill] = res;
                  stack_fill++;
               end
            end
         end
         CMD_FINISH: begin
            if (stack_fill > 0) begin
               ans.top_value = stack_cells[stack_fill-1];
               ans.top_valid = 1'b1;
            end
            stack_fill = 0;
         end
         default: ;
      endcase
      if (tok.command != CMD_FINISH && stack_fill > 0) begin
         ans.top_value = stack_cells[stack_fill-1];
         ans.top_valid = 1'b1;
      end
      ans.stack_count = COUNT_OUT_W'(stack_fill);
      return ans;
   endfunction

   // result beat first: it belongs to a token taken at an earlier edge
   always @(posedge clock) begin
      if (reset) begin
         owed_answers.delete();
         stack_fill = 0;
      end else begin
         if (rsp_valid) begin
            if (owed_answers.size() == 0) begin
               report_mismatch("unexpected result beat, status", rsp_item.status, '0);
            end else begin
               oldest = owed_answers.pop_front();
               if (rsp_item.top_value !== oldest.top_value)
                  report_mismatch("top_value", rsp_item.top_value, oldest.top_value);
               if (rsp_item.top_valid !== oldest.top_valid)
                  report_mismatch("top_valid", rsp_item.top_valid, oldest.top_valid);
               if (rsp_item.stack_count !== oldest.stack_count)
                  report_mismatch("stack_count", rsp_item.stack_count, oldest.stack_count);
               if (rsp_item.status !== oldest.status)
                  report_mismatch("status", rsp_item.status, oldest.status);
            end
         end
         if (start && !busy) begin
            owed_answers.push_back(evaluate_token(req_item));
         end
      end
      answers_owed <= owed_answers.size();
   end

endmodule

FILE: verif/tb_rpn_stack_evaluator.sv
// Testbench top for the RPN stack evaluator: token stimulus, checker hookup, verdict.
module tb_rpn_stack_evaluator;
   import rse_pkg::*;

   // codes the block treats as no-ops
   localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
   localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

   localparam logic [DATA_W-1:0] MOST_POS = 32'h7fff_ffff;
   localparam logic [DATA_W-1:0] MOST_NEG = 32'h8000_0000;
   localparam logic [DATA_W-1:0] MINUS_ONE = 32'hffff_ffff;

   localparam int RANDOM_TOKENS = 2000;
   localparam int DRAIN_CYCLES  = 40;   // longer than one divide

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_item;
   logic    rsp_valid;
   rsp_type rsp_item;
   int      mismatch_count;
   int      answers_owed;

   // rough stack depth, only used to shape stimulus toward deep expressions
   int      depth_guess;
   // when set, the sender drives tokens back to back
   bit      steady_run;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   rpn_stack_evaluator uut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   rpn_result_checker watch (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_item       (req_item),
      .rsp_valid      (rsp_valid),
      .rsp_item       (rsp_item),
      .mismatch_count (mismatch_count),
      .answers_owed   (answers_owed)
   );

   // hard stop: ~2400 tokens at the worst divide time plus the longest gap each is far below this
   initial begin
      #20_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // Offers one token and returns at the edge that takes it. Called at a rising
   // edge. With no gap, start stays high from the previous beat, so start only
   // ever gets one assignment per edge.
   task automatic send_token(input logic [CMD_W-1:0] cmd, input logic [DATA_W-1:0] val);
      int      gap;
      bit      taken;
      req_type tok;
      gap = steady_run ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      tok.command = cmd;
      tok.value   = val;
      start    <= 1'b1;
      req_item <= tok;
      taken = 1'b0;
      // busy is settled mid-cycle; that value decides the next edge
      while (!taken) begin
         @(negedge clock);
         taken = !busy;
         @(posedge clock);
      end
      case (cmd)
         CMD_PUSH: if (depth_guess < STACK_DEPTH_DEF) depth_guess++;
         CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV: depth_guess = (depth_guess >= 2) ? depth_guess - 1 : 0;
         CMD_FINISH: depth_guess = 0;
         default: ;
      endcase
   endtask

   // extremes, small numbers around zero (zero divisors show up here), or anything
   function automatic logic [DATA_W-1:0] random_operand();
      case ($urandom_range(0, 5))
         0: begin
            case ($urandom_range(0, 4))
               0: return '0;
               1: return 32'd1;
               2: return MINUS_ONE;
               3: return MOST_POS;
               default: return MOST_NEG;
            endcase
         end
         1, 2: return DATA_W'($urandom_range(0, 20)) - 32'd10;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [CMD_W-1:0] random_operator();
      case ($urandom_range(0, 3))
         0: return CMD_ADD;
         1: return CMD_SUB;
         2: return CMD_MUL;
         default: return CMD_DIV;
      endcase
   endfunction

   initial begin
      int n;
      int pick;
      reset       = 1'b1;
      start       = 1'b0;
      req_item    = '0;
      depth_guess = 0;
      steady_run  = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // ---- directed tokens ----
      // operator on an empty stack: underflow, nothing moves
      send_token(CMD_ADD, '0);
      // operator with a single entry: entry lost, underflow
      send_token(CMD_PUSH, 32'd9);
      send_token(CMD_SUB, MINUS_ONE);
      // add overflow wraps to most negative
      send_token(CMD_PUSH, MOST_POS);
      send_token(CMD_PUSH, 32'd1);
      send_token(CMD_ADD, '0);
      // most negative / -1 wraps back to most negative, status ok
      send_token(CMD_PUSH, MINUS_ONE);
      send_token(CMD_DIV, '0);
      // divide by zero: both operands dropped, stack ends empty
      send_token(CMD_PUSH, '0);
      send_token(CMD_DIV, '0);
      // truncating divide of mixed signs, then multiply and subtract overflow
      send_token(CMD_PUSH, -32'sd7);
      send_token(CMD_PUSH, 32'd2);
      send_token(CMD_DIV, '0);
      send_token(CMD_PUSH, MOST_NEG);
      send_token(CMD_MUL, '0);
      send_token(CMD_PUSH, MOST_POS);
      send_token(CMD_SUB, '0);
      // fill to the top, then one push too many gets dropped
      for (n = 0; n < STACK_DEPTH_DEF; n++) begin
         send_token(CMD_PUSH, (n % 2) ? MOST_NEG : MOST_POS);
      end
      // unused codes report the top and change nothing
      send_token(CMD_SPARE_LO, MINUS_ONE);
      send_token(CMD_SPARE_HI, '0);
      // finish reports the top before clearing; again on the empty stack
      send_token(CMD_FINISH, '0);
      send_token(CMD_FINISH, MINUS_ONE);

      // ---- random tokens ----
      // Mostly well-formed expressions with random operands; some operators on a
      // shallow stack, spare codes, early finishes and fill-up bursts as noise.
      for (n = 0; n < RANDOM_TOKENS; n++) begin
         if (n % 100 == 0) steady_run = ($urandom_range(0, 3) == 0);
         pick = $urandom_range(0, 99);
         if (pick < 1) begin
            repeat (STACK_DEPTH_DEF + 2) send_token(CMD_PUSH, random_operand());
         end else if (pick < 6) begin
            send_token(CMD_FINISH, random_operand());
         end else if (pick < 8) begin
            send_token($urandom_range(0, 1) ? CMD_SPARE_HI : CMD_SPARE_LO, random_operand());
         end else if (pick < 14) begin
            send_token(random_operator(), random_operand());
         end else if (depth_guess < 2 || (depth_guess < STACK_DEPTH_DEF && pick < 58)) begin
            send_token(CMD_PUSH, random_operand());
         end else begin
            send_token(random_operator(), random_operand());
         end
      end
      start <= 1'b0;

      // let the owed count catch up with the last beat, then wait it out
      @(posedge clock);
      while (answers_owed != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
